>>> rtl/euler_zyx_instance_transform_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the instance transform unit
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef EULER_ZYX_INSTANCE_TRANSFORM_UNIT_DEFINES_SVH
`define EULER_ZYX_INSTANCE_TRANSFORM_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition holds at every edge
`define EZIT_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// consequence holds at the clock edge after the antecedent
`define EZIT_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define EZIT_CHECK(lbl, cond, msg)
`define EZIT_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/ezit_pkg.sv
// ----------------------------------------------------------------------------
// ezit_pkg
// Shared types, fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
package ezit_pkg;

	// angle accumulator and CORDIC vector width (Q2.30 with headroom)
	localparam int ZW = 34;
	localparam int TW = 18;   // sine/cosine at Q.16
	localparam int ATAN_LEN = 24;

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ZW-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0]        pos_x;
		logic signed [31:0]        pos_y;
		logic signed [31:0]        pos_z;
		logic [15:0]               scale;
		logic [2:0]                neg;
		logic [2:0][ZW-1:0]        z;
	} front_item_t;

	localparam int ITEM_W = $bits(front_item_t);

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        scale;
	} carry_t;

	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				5'd0:    r = 34'sh03243F6A8;
				5'd1:    r = 34'sh01DAC6705;
				5'd2:    r = 34'sh00FADBAFC;
				5'd3:    r = 34'sh007F56EA6;
				5'd4:    r = 34'sh003FEAB76;
				5'd5:    r = 34'sh001FFD55B;
				5'd6:    r = 34'sh000FFFAAA;
				5'd7:    r = 34'sh0007FFF55;
				5'd8:    r = 34'sh0003FFFEA;
				5'd9:    r = 34'sh0001FFFFD;
				5'd10:   r = 34'sh0000FFFFF;
				5'd11:   r = 34'sh00007FFFF;
				5'd12:   r = 34'sh00003FFFF;
				5'd13:   r = 34'sh00001FFFF;
				5'd14:   r = 34'sh00000FFFF;
				5'd15:   r = 34'sh000007FFF;
				5'd16:   r = 34'sh000003FFF;
				5'd17:   r = 34'sh000001FFF;
				5'd18:   r = 34'sh000000FFF;
				5'd19:   r = 34'sh0000007FF;
				5'd20:   r = 34'sh0000003FF;
				5'd21:   r = 34'sh0000001FF;
				5'd22:   r = 34'sh0000000FF;
				5'd23:   r = 34'sh00000007F;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

>>> rtl/ezit_front.sv
// ----------------------------------------------------------------------------
// ezit_front
// Input register: unpacks a word and folds each angle into +-pi/2.
// ----------------------------------------------------------------------------
module ezit_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [159:0]        in_data,
	output logic                item_valid,
	input  logic                item_ready,
	output ezit_pkg::front_item_t item
);
	import ezit_pkg::*;

	front_item_t fold;
	logic        valid_q;
	front_item_t item_q;

	always_comb begin
		logic signed [15:0]   ang;
		logic signed [ZW-1:0] zf;
		fold.pos_x = $signed(in_data[31:0]);
		fold.pos_y = $signed(in_data[63:32]);
		fold.pos_z = $signed(in_data[95:64]);
		fold.scale = in_data[159:144];
		for (int a = 0; a < 3; a++) begin
			ang = $signed(in_data[96 + 16*a +: 16]);
			zf  = $signed({ang[15], ang, 17'b0});
			fold.neg[a] = 1'b0;
			if (zf > HALF_PI_Q30) begin
				zf = zf - PI_Q30;
				fold.neg[a] = 1'b1;
			end else if (zf < -HALF_PI_Q30) begin
				zf = zf + PI_Q30;
				fold.neg[a] = 1'b1;
			end
			fold.z[a] = zf;
		end
	end

	assign in_ready   = !valid_q || item_ready;
	assign item_valid = valid_q;
	assign item       = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= fold;
		end
	end

endmodule

>>> rtl/ezit_fifo.sv
// ----------------------------------------------------------------------------
// ezit_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
`include "euler_zyx_instance_transform_unit_defines.svh"

module ezit_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    count_q;
	logic             wr, rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	`EZIT_CHECK(a_count_range, count_q <= CW'(DEPTH), "queue count beyond depth")
	`EZIT_CHECK_NEXT(a_fill, wr && !rd, count_q == $past(count_q) + 1'b1, "queue fill lost")
	`EZIT_CHECK_NEXT(a_drain, rd && !wr, count_q == $past(count_q) - 1'b1, "queue drain lost")

endmodule

>>> rtl/ezit_back.sv
// ----------------------------------------------------------------------------
// ezit_back
// CORDIC pipeline for three angles, matrix products, scale and saturate.
// ----------------------------------------------------------------------------
module ezit_back #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_pop,
	input  ezit_pkg::front_item_t item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [327:0]          out_data
);
	import ezit_pkg::*;

	localparam int N  = (TRIG_ITERATIONS > ATAN_LEN) ? ATAN_LEN : TRIG_ITERATIONS;
	localparam int PW = 2 * TW;          // pair product
	localparam int TPW = PW + TW;        // triple product
	localparam int QW = 56;              // Q.48 entry
	localparam int RW = 28;              // Q.24 entry
	localparam int SW = RW + 17;         // scaled entry
	localparam int MW = 25;

	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign item_pop = en && item_valid;

	// CORDIC stages: index k holds the vector before iteration k
	logic signed [ZW-1:0] cd_x_s [N+1][3];
	logic signed [ZW-1:0] cd_y_s [N+1][3];
	logic signed [ZW-1:0] cd_z_s [N+1][3];
	logic [2:0]           neg_s  [N+1];
	carry_t               pay_s  [N+1];
	logic [N:0]           vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				cd_x_s[0][a] <= CORDIC_GAIN;
				cd_y_s[0][a] <= '0;
				cd_z_s[0][a] <= $signed(item.z[a]);
			end
			neg_s[0]       <= item.neg;
			pay_s[0].pos_x <= item.pos_x;
			pay_s[0].pos_y <= item.pos_y;
			pay_s[0].pos_z <= item.pos_z;
			pay_s[0].scale <= item.scale;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_iter
		for (genvar a = 0; a < 3; a++) begin : g_axis
			logic signed [ZW-1:0] dx, dy;
			assign dx = cd_y_s[k][a] >>> k;
			assign dy = cd_x_s[k][a] >>> k;
			always_ff @(posedge clk) begin
				if (en) begin
					if (!cd_z_s[k][a][ZW-1]) begin
						cd_x_s[k+1][a] <= cd_x_s[k][a] - dx;
						cd_y_s[k+1][a] <= cd_y_s[k][a] + dy;
						cd_z_s[k+1][a] <= cd_z_s[k][a] - atan_q30(5'(k));
					end else begin
						cd_x_s[k+1][a] <= cd_x_s[k][a] + dx;
						cd_y_s[k+1][a] <= cd_y_s[k][a] - dy;
						cd_z_s[k+1][a] <= cd_z_s[k][a] + atan_q30(5'(k));
					end
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k+1] <= neg_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	// s1: undo the half-turn fold and round to Q.16 (0 = x, 1 = y, 2 = z)
	logic signed [TW-1:0] sn_s1 [3];
	logic signed [TW-1:0] cs_s1 [3];
	carry_t               pay_s1, pay_s2, pay_s3, pay_s4, pay_s5, pay_s6;
	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	always_ff @(posedge clk) begin
		logic signed [ZW-1:0] xn, yn, xr, yr;
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				xn = neg_s[N][a] ? -cd_x_s[N][a] : cd_x_s[N][a];
				yn = neg_s[N][a] ? -cd_y_s[N][a] : cd_y_s[N][a];
				xr = (xn + ZW'(8192)) >>> 14;
				yr = (yn + ZW'(8192)) >>> 14;
				cs_s1[a] <= xr[TW-1:0];
				sn_s1[a] <= yr[TW-1:0];
			end
			pay_s1 <= pay_s[N];
		end
	end

	// s2: pair products
	logic signed [PW-1:0] czcy_s2, szcx_s2, czsy_s2, szsx_s2, czcx_s2;
	logic signed [PW-1:0] szsy_s2, czsx_s2, cysx_s2, cycx_s2, szcy_s2;
	logic signed [TW-1:0] sx_s2, cx_s2, sy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			czcy_s2 <= cs_s1[2] * cs_s1[1];
			szcx_s2 <= sn_s1[2] * cs_s1[0];
			czsy_s2 <= cs_s1[2] * sn_s1[1];
			szsx_s2 <= sn_s1[2] * sn_s1[0];
			czcx_s2 <= cs_s1[2] * cs_s1[0];
			szsy_s2 <= sn_s1[2] * sn_s1[1];
			czsx_s2 <= cs_s1[2] * sn_s1[0];
			cysx_s2 <= cs_s1[1] * sn_s1[0];
			cycx_s2 <= cs_s1[1] * cs_s1[0];
			szcy_s2 <= sn_s1[2] * cs_s1[1];
			sx_s2   <= sn_s1[0];
			cx_s2   <= cs_s1[0];
			sy_s2   <= sn_s1[1];
			pay_s2  <= pay_s1;
		end
	end

	// s3: triple products, pass pairs along
	logic signed [TPW-1:0] t01_s3, t02_s3, t11_s3, t12_s3;
	logic signed [PW-1:0]  czcy_s3, szcx_s3, szsx_s3, czcx_s3;
	logic signed [PW-1:0]  czsx_s3, cysx_s3, cycx_s3, szcy_s3;
	logic signed [TW-1:0]  sy_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			t01_s3  <= czsy_s2 * sx_s2;
			t02_s3  <= czsy_s2 * cx_s2;
			t11_s3  <= szsy_s2 * sx_s2;
			t12_s3  <= szsy_s2 * cx_s2;
			czcy_s3 <= czcy_s2;
			szcx_s3 <= szcx_s2;
			szsx_s3 <= szsx_s2;
			czcx_s3 <= czcx_s2;
			czsx_s3 <= czsx_s2;
			cysx_s3 <= cysx_s2;
			cycx_s3 <= cycx_s2;
			szcy_s3 <= szcy_s2;
			sy_s3   <= sy_s2;
			pay_s3  <= pay_s2;
		end
	end

	// s4: Q.48 entries, already in Y-up order (row-major m00..m22)
	logic signed [QW-1:0] e_s4 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			e_s4[0] <= QW'(czcy_s3) <<< 16;                        // R00
			e_s4[1] <= (QW'(szsx_s3) <<< 16) + QW'(t02_s3);         // R02
			e_s4[2] <= QW'(t01_s3) - (QW'(szcx_s3) <<< 16);         // R01
			e_s4[3] <= -(QW'(sy_s3) <<< 32);                        // R20
			e_s4[4] <= QW'(cycx_s3) <<< 16;                         // R22
			e_s4[5] <= QW'(cysx_s3) <<< 16;                         // R21
			e_s4[6] <= QW'(szcy_s3) <<< 16;                         // R10
			e_s4[7] <= QW'(t12_s3) - (QW'(czsx_s3) <<< 16);         // R12
			e_s4[8] <= (QW'(czcx_s3) <<< 16) + QW'(t11_s3);         // R11
			pay_s4  <= pay_s3;
		end
	end

	// s5: round to Q.24
	logic signed [RW-1:0] q24_s5 [9];

	always_ff @(posedge clk) begin
		logic signed [QW-1:0] r;
		if (en) begin
			for (int j = 0; j < 9; j++) begin
				r = (e_s4[j] + (QW'(1) <<< 23)) >>> 24;
				q24_s5[j] <= r[RW-1:0];
			end
			pay_s5 <= pay_s4;
		end
	end

	// s6: apply scale
	logic signed [SW-1:0] sc_s6 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 9; j++) begin
				sc_s6[j] <= q24_s5[j] * $signed({1'b0, pay_s5.scale});
			end
			pay_s6 <= pay_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= vld_s[N];
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			out_valid_q <= vld_s6;
		end
	end

	// output register: round to Q.16 and clamp
	logic [MW-1:0]  m_q [9];
	carry_t         pay_q;

	always_ff @(posedge clk) begin
		logic signed [SW-1:0] v;
		if (en) begin
			for (int j = 0; j < 9; j++) begin
				v = (sc_s6[j] + (SW'(1) <<< 15)) >>> 16;
				if (v > SW'(16777215)) begin
					m_q[j] <= 25'h0FFFFFF;
				end else if (v < -SW'(16777216)) begin
					m_q[j] <= 25'h1000000;
				end else begin
					m_q[j] <= v[MW-1:0];
				end
			end
			pay_q <= pay_s6;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {7'b0, pay_q.pos_y, pay_q.pos_z, pay_q.pos_x,
		m_q[8], m_q[7], m_q[6], m_q[5], m_q[4], m_q[3], m_q[2], m_q[1], m_q[0]};

endmodule

>>> rtl/euler_zyx_instance_transform_unit.sv
// ----------------------------------------------------------------------------
// euler_zyx_instance_transform_unit
// Builds the scaled Y-up 3x4 transform of a placed object from its Z-up
// position, ZYX Euler angles and uniform scale.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit first)
//  s_axis    in   pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_factor
//  m_axis    out  m00..m22, trans_x, trans_y, trans_z
//
//  One word per cycle sustained while the output word is not held; the CORDIC
//  pipeline has one stage per iteration.
//  arst_n clears all valid flags; data registers are not reset.
//  A held output word stalls the back pipeline; the front and its two-word
//  queue keep taking input until the queue fills.
// ----------------------------------------------------------------------------
module euler_zyx_instance_transform_unit #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_factor
	input  logic [159:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, trans_x, trans_y, trans_z, pad
	output logic [327:0] m_axis_tdata
);
	import ezit_pkg::*;

	logic        fr_valid, fr_ready;
	front_item_t fr_item, q_item;
	logic        q_full, q_empty, q_pop;

	ezit_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.item_valid (fr_valid),
		.item_ready (fr_ready),
		.item       (fr_item)
	);

	assign fr_ready = !q_full;

	ezit_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (2)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_valid),
		.full   (q_full),
		.wdata  (fr_item),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_item)
	);

	ezit_back #(
		.TRIG_ITERATIONS (TRIG_ITERATIONS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!q_empty),
		.item_pop   (q_pop),
		.item       (q_item),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams placed-object words into the transform unit and compares every
// output word with a fixed-point rotation/scale predictor, under random
// bursts, gaps, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int N_ITER = 16;
	localparam int LAT = N_ITER + 9;

	localparam logic signed [63:0] GAIN_Q30   = 64'sd652032874;
	localparam logic signed [63:0] HALFPI_Q30 = 64'sd1686629713;
	localparam logic signed [63:0] PI_Q30V    = 64'sd3373259426;
	localparam logic signed [63:0] ENT_MAX    = 64'sd16777215;
	localparam logic signed [63:0] ENT_MIN    = -64'sd16777216;

	typedef struct packed {
		logic [15:0] scale_factor;
		logic [15:0] angle_z;
		logic [15:0] angle_y;
		logic [15:0] angle_x;
		logic [31:0] pos_z;
		logic [31:0] pos_y;
		logic [31:0] pos_x;
	} placement_t;

	typedef struct packed {
		logic [6:0]  pad;
		logic [31:0] trans_z;
		logic [31:0] trans_y;
		logic [31:0] trans_x;
		logic [8:0][24:0] m;   // m[0] = m00 ... m[8] = m22
	} xform_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [327:0] m_axis_tdata;

	xform_t expected_xforms[$];
	int     errors = 0;
	bit     hold_off = 1'b0;
	bit     stall_on = 1'b1;
	bit     gaps_on = 1'b1;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	euler_zyx_instance_transform_unit #(.TRIG_ITERATIONS(N_ITER)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [63:0] round_shr(logic signed [63:0] v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [63:0] atan_entry(int i);
		logic signed [63:0] tbl[24];
		tbl = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
			64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
			64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
		return tbl[i];
	endfunction

	// CORDIC sine and cosine of a Q3.13 angle, both Q.16
	function automatic void sin_cos(input logic [15:0] ang, output logic signed [63:0] s,
			output logic signed [63:0] c);
		logic signed [63:0] z, x, y, dx, dy;
		bit flip;
		int n;
		z = 64'(signed'(ang)) * 131072;
		x = GAIN_Q30;
		y = 0;
		flip = 1'b0;
		n = (N_ITER > 24) ? 24 : N_ITER;
		if (z > HALFPI_Q30) begin
			z -= PI_Q30V;
			flip = 1'b1;
		end else if (z < -HALFPI_Q30) begin
			z += PI_Q30V;
			flip = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_entry(i);
			end else begin
				x += dx; y -= dy; z += atan_entry(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = round_shr(x, 14);
		s = round_shr(y, 14);
	endfunction

	function automatic logic [24:0] scaled_entry(logic signed [63:0] q48, logic [15:0] sc);
		logic signed [63:0] v;
		v = round_shr(round_shr(q48, 24) * $signed({48'd0, sc}), 16);
		if (v > ENT_MAX) v = ENT_MAX;
		if (v < ENT_MIN) v = ENT_MIN;
		return v[24:0];
	endfunction

	function automatic xform_t predict_xform(placement_t p);
		logic signed [63:0] sx, cx, sy, cy, sz, cz;
		logic signed [63:0] r[3][3];
		int perm[3];
		xform_t t;
		perm = '{0, 2, 1};
		sin_cos(p.angle_x, sx, cx);
		sin_cos(p.angle_y, sy, cy);
		sin_cos(p.angle_z, sz, cz);
		r[0][0] = cz * cy * 65536;
		r[0][1] = -sz * cx * 65536 + cz * sy * sx;
		r[0][2] = sz * sx * 65536 + cz * sy * cx;
		r[1][0] = sz * cy * 65536;
		r[1][1] = cz * cx * 65536 + sz * sy * sx;
		r[1][2] = -cz * sx * 65536 + sz * sy * cx;
		r[2][0] = -sy * 65536 * 65536;
		r[2][1] = cy * sx * 65536;
		r[2][2] = cy * cx * 65536;
		t = '0;
		for (int row = 0; row < 3; row++)
			for (int col = 0; col < 3; col++)
				t.m[row * 3 + col] = scaled_entry(r[perm[row]][perm[col]], p.scale_factor);
		t.trans_x = p.pos_x;
		t.trans_y = p.pos_z;
		t.trans_z = p.pos_y;
		return t;
	endfunction

	// random gap first, then offer the word and hold until taken
	task automatic send_placement(placement_t p);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tdata <= p;
		s_axis_tvalid <= 1'b1;
		expected_xforms = {expected_xforms, predict_xform(p)};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic placement_t rand_placement();
		placement_t p;
		p.pos_x = $urandom;
		p.pos_y = $urandom;
		p.pos_z = $urandom;
		p.angle_x = $urandom;
		p.angle_y = $urandom;
		p.angle_z = $urandom;
		case ($urandom_range(0, 3))
			0: p.scale_factor = $urandom;
			1: p.scale_factor = $urandom_range(0, 1024);
			2: p.scale_factor = 16'h0100;
			default: p.scale_factor = 16'hFF00 | 16'($urandom_range(0, 255));
		endcase
		return p;
	endfunction

	// drop the input and wait for every expected word
	task automatic drain();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (expected_xforms.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic test_directed();
		logic [15:0] angs[8];
		placement_t p;
		angs = '{16'h0000, 16'h7FFF, 16'h8000, 16'h3244, 16'hCDBC, 16'h3243, 16'h6488, 16'h9B78};
		foreach (angs[i]) begin
			p = '{16'h0100, angs[i], angs[(i + 3) % 8], angs[(i + 5) % 8],
				32'h7FFFFFFF, 32'h80000000, 32'(i)};
			send_placement(p);
		end
		// zero scale, full scale (saturation), smallest nonzero scale, translation extremes
		send_placement('{16'h0000, 16'h1234, 16'h4321, 16'hABCD,
			32'hFFFFFFFF, 32'h00000000, 32'h80000000});
		send_placement('{16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
			32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF});
		send_placement('{16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 32'h1, 32'h2, 32'h3});
		send_placement('{16'hFFFF, 16'h1922, 16'hE6DE, 16'h1922,
			32'hA5A5A5A5, 32'h5A5A5A5A, 32'hFFFFFFFF});
		send_placement('{16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0});
		send_placement('{16'h8000, 16'hFFFF, 16'h0001, 16'hFFFF,
			32'h12345678, 32'h87654321, 32'hDEADBEEF});
	endtask

	task automatic test_random();
		repeat (500) send_placement(rand_placement());
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		hold_off = 1'b1;
		gaps_on = 1'b0;
		repeat (40) send_placement(rand_placement());
		drain();
		wait (!hold_off);
		gaps_on = 1'b1;
	endtask

	task automatic test_back_to_back();
		stall_on = 1'b0;
		gaps_on = 1'b0;
		repeat (30) send_placement(rand_placement());
		drain();
		stall_on = 1'b1;
		gaps_on = 1'b1;
	endtask

	// receiver stall pattern, and a long counted hold-off on request
	initial begin
		int cnt;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				for (cnt = 0; cnt < 300; cnt++) @(posedge clk);
				hold_off = 1'b0;
			end
			m_axis_tready <= !stall_on || ($urandom_range(0, 9) > 2);
		end
	end

	always @(posedge clk) begin
		xform_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_xforms.size() == 0) begin
				$display("%0t: unexpected word %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = expected_xforms.pop_front();
				for (int k = 0; k < 9; k++)
					if (got.m[k] !== want.m[k]) begin
						$display("%0t: m%0d%0d expected %h actual %h",
							$time, k / 3, k % 3, want.m[k], got.m[k]);
						errors++;
					end
				if (got.trans_x !== want.trans_x) begin
					$display("%0t: trans_x expected %h actual %h", $time, want.trans_x,
						got.trans_x);
					errors++;
				end
				if (got.trans_y !== want.trans_y) begin
					$display("%0t: trans_y expected %h actual %h", $time, want.trans_y,
						got.trans_y);
					errors++;
				end
				if (got.trans_z !== want.trans_z) begin
					$display("%0t: trans_z expected %h actual %h", $time, want.trans_z,
						got.trans_z);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain();
		test_backpressure();
		test_random();
		test_back_to_back();
		repeat (LAT * 4) @(posedge clk);
		if (errors == 0 && expected_xforms.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#200000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ezit_pkg.sv
rtl/ezit_front.sv
rtl/ezit_fifo.sv
rtl/ezit_back.sv
rtl/euler_zyx_instance_transform_unit.sv
tb/tb_top.sv
